// ===== rtl/core/scrdsp_pkg.sv =====
// shared types and constants for the scrolling four-digit display driver
// no dependencies; used by scrolling_four_digit_display_mux
`default_nettype none

package scrdsp_pkg;

  // field widths
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int DWELL_W = 8;
  localparam int DIGIT_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  localparam int TEXT_DEPTH_DEF = 64;

  localparam int NUM_DIGITS       = 4;
  localparam int SHORT_TEXT_LEN   = 5;
  localparam int SHORT_TEXT_START = 4;
  localparam int SCROLL_TAIL      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_REFRESH = 2'd0,
    KIND_SCROLL  = 2'd1,
    KIND_WRITE   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_LENGTH  = 2'd0,
    REG_WINDOW_START = 2'd1,
    REG_DWELL_TICKS  = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/scrolling_four_digit_display_mux.sv =====
// scrolling four-digit multiplexed segment display driver, top level
// text store banked four ways, input register, bank read stage, output register with skid
// depends on scrdsp_pkg
//
//   channel | direction | handshake         | payload
//   s_*     | in        | s_tvalid/s_tready | tuser kind, tdata text_index, text_byte
//   m_*     | out       | m_tvalid/m_tready | tdata segment_byte, tuser digit_select
//   cfg_*   | in        | cfg_we            | cfg_index, cfg_data
//
// one item is taken every cycle while s_tready is high; a result passes through the
// input register, then the text bank read register, then the output register
// reset clears every text store entry at once through per-entry valid bits
// s_tready falls only while a result sits in the skid register behind a stalled m_tready
`default_nettype none

module scrolling_four_digit_display_mux #(
  parameter int TEXT_DEPTH = scrdsp_pkg::TEXT_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [5:0] text_index, [13:6] text_byte, [15:14] zero
  input  wire logic [scrdsp_pkg::S_DATA_W-1:0]   s_tdata,
  // [1:0] kind
  input  wire logic [scrdsp_pkg::KIND_W-1:0]     s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [7:0] segment_byte
  output logic [scrdsp_pkg::M_DATA_W-1:0]        m_tdata,
  // [1:0] digit_select
  output logic [scrdsp_pkg::DIGIT_W-1:0]         m_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [scrdsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scrdsp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int BANKS      = scrdsp_pkg::NUM_DIGITS;
  localparam int BANK_DEPTH = (TEXT_DEPTH + BANKS - 1) / BANKS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int POS_W      = scrdsp_pkg::LEN_W + 1;
  localparam int LEN_W      = scrdsp_pkg::LEN_W;
  localparam int BYTE_W     = scrdsp_pkg::BYTE_W;
  localparam int DWELL_W    = scrdsp_pkg::DWELL_W;
  localparam int DIGIT_W    = scrdsp_pkg::DIGIT_W;

  // configuration registers
  logic [LEN_W-1:0]   text_length;
  logic [LEN_W-1:0]   window_start;
  logic [DWELL_W-1:0] dwell_ticks;
  logic [LEN_W-1:0]   scroll_position;
  logic [LEN_W-1:0]   scroll_position_next;

  // input register
  logic                s1_valid;
  scrdsp_pkg::kind_t   s1_kind;
  logic [LEN_W-1:0]    s1_index;
  logic [BYTE_W-1:0]   s1_byte;

  // bank read stage
  logic                s2_valid;
  scrdsp_pkg::kind_t   s2_kind;
  logic                s2_latch;
  logic [DIGIT_W-1:0]  s2_start_lo;
  logic [BYTE_W-1:0]   rd_data [BANKS];
  logic                rd_ok   [BANKS];

  // text store, banked by position mod 4 so a window reads each bank once
  logic [BYTE_W-1:0]     bank_mem [BANKS][BANK_DEPTH];
  logic [BANK_DEPTH-1:0] bank_vld [BANKS];

  // display state
  logic [BYTE_W-1:0]  digit_bytes      [BANKS];
  logic [BYTE_W-1:0]  digit_bytes_next [BANKS];
  logic [DIGIT_W-1:0] current_digit;
  logic [DWELL_W-1:0] dwell_countdown;
  logic [DIGIT_W-1:0] current_digit_next;
  logic [DWELL_W-1:0] dwell_countdown_next;

  // output register and skid
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic [DIGIT_W-1:0] out_digit;
  logic               skid_valid;
  logic [BYTE_W-1:0]  skid_byte;
  logic [DIGIT_W-1:0] skid_digit;

  logic               adv;
  logic               take;
  logic               res_valid;
  logic [BYTE_W-1:0]  res_byte;
  logic [DIGIT_W-1:0] res_digit;

  // stage one decode
  logic               len_short;
  logic               pos_ok;
  logic               s1_scroll;
  logic               s1_latch;
  logic [LEN_W-1:0]   win_start;
  logic [BA_W-1:0]    rd_addr  [BANKS];
  logic               rd_range [BANKS];
  logic               wr_en;
  logic [DIGIT_W-1:0] wr_bank;
  logic [BA_W-1:0]    wr_addr;
  logic [LEN_W-1:0]   cfg_win;

  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign take     = m_tvalid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_digit;

  assign cfg_win = cfg_data[LEN_W-1:0];

  assign len_short = text_length < LEN_W'(scrdsp_pkg::SHORT_TEXT_LEN);
  assign pos_ok    = {1'b0, scroll_position}
                     <= ({1'b0, text_length} + POS_W'(scrdsp_pkg::SCROLL_TAIL));
  assign s1_scroll = s1_valid && (s1_kind == scrdsp_pkg::KIND_SCROLL);
  assign s1_latch  = s1_scroll && (len_short || (window_start != '0) || pos_ok);

  always_comb begin
    if (len_short) begin
      win_start = LEN_W'(scrdsp_pkg::SHORT_TEXT_START);
    end else if (window_start != '0) begin
      win_start = window_start;
    end else begin
      win_start = scroll_position;
    end
  end

  // per-bank read address for the window start..start+3
  always_comb begin
    logic [DIGIT_W-1:0] off;
    logic [POS_W-1:0]   pos;
    for (int b = 0; b < BANKS; b++) begin
      off         = DIGIT_W'(b) - win_start[DIGIT_W-1:0];
      pos         = {1'b0, win_start} + POS_W'(off);
      rd_range[b] = 32'(pos) < 32'(TEXT_DEPTH);
      rd_addr[b]  = rd_range[b] ? BA_W'(32'(pos) >> 2) : '0;
    end
  end

  assign wr_en   = adv && s1_valid && (s1_kind == scrdsp_pkg::KIND_WRITE)
                   && (32'(s1_index) < 32'(TEXT_DEPTH));
  assign wr_bank = s1_index[DIGIT_W-1:0];
  assign wr_addr = BA_W'(32'(s1_index) >> 2);

  always_comb begin
    scroll_position_next = scroll_position;
    if (cfg_we && (cfg_index == scrdsp_pkg::REG_TEXT_LENGTH)) begin
      scroll_position_next = '0;
    end else if (adv && s1_scroll && !len_short && (window_start == '0)) begin
      scroll_position_next = pos_ok ? scroll_position + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length     <= '0;
      window_start    <= '0;
      dwell_ticks     <= DWELL_W'(1);
      scroll_position <= '0;
    end else begin
      scroll_position <= scroll_position_next;
      if (cfg_we) begin
        case (cfg_index)
          scrdsp_pkg::REG_TEXT_LENGTH: begin
            text_length <= cfg_win;
          end
          scrdsp_pkg::REG_WINDOW_START: begin
            // the start is checked against the length only when written
            window_start <= ((cfg_win != '0) && (cfg_win <= text_length)) ? cfg_win : '0;
          end
          scrdsp_pkg::REG_DWELL_TICKS: begin
            dwell_ticks <= cfg_data[DWELL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= scrdsp_pkg::kind_t'(s_tuser);
      s1_index <= s_tdata[LEN_W-1:0];
      s1_byte  <= s_tdata[LEN_W+BYTE_W-1:LEN_W];
    end
  end

  // text banks: one write and one registered read per bank
  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (wr_en && (wr_bank == DIGIT_W'(b))) begin
        bank_mem[b][wr_addr] <= s1_byte;
      end
      if (adv) begin
        rd_data[b] <= bank_mem[b][rd_addr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANKS; b++) begin
        bank_vld[b] <= '0;
        rd_ok[b]    <= 1'b0;
      end
    end else begin
      for (int b = 0; b < BANKS; b++) begin
        if (wr_en && (wr_bank == DIGIT_W'(b))) begin
          bank_vld[b][wr_addr] <= 1'b1;
        end
        if (adv) begin
          rd_ok[b] <= rd_range[b] && bank_vld[b][rd_addr[b]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_latch <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s2_latch <= s1_latch;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind     <= s1_kind;
      s2_start_lo <= win_start[DIGIT_W-1:0];
    end
  end

  // digit latch and refresh countdown
  always_comb begin
    logic [DIGIT_W-1:0] b;
    for (int k = 0; k < BANKS; k++) begin
      b                   = s2_start_lo + DIGIT_W'(k);
      digit_bytes_next[k] = digit_bytes[k];
      if (s2_latch) begin
        digit_bytes_next[k] = rd_ok[b] ? rd_data[b] : '0;
      end
    end
  end

  always_comb begin
    res_valid            = 1'b0;
    res_byte             = digit_bytes[current_digit];
    res_digit            = current_digit;
    current_digit_next   = current_digit;
    dwell_countdown_next = dwell_countdown;
    if (s2_valid && (s2_kind == scrdsp_pkg::KIND_REFRESH)) begin
      if (dwell_countdown == '0) begin
        res_valid            = 1'b1;
        current_digit_next   = current_digit + 1'b1;
        // a dwell of zero behaves as one
        dwell_countdown_next = (dwell_ticks == '0) ? '0 : dwell_ticks - 1'b1;
      end else begin
        dwell_countdown_next = dwell_countdown - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_digit   <= '0;
      dwell_countdown <= '0;
      for (int k = 0; k < BANKS; k++) begin
        digit_bytes[k] <= '0;
      end
    end else if (adv) begin
      current_digit   <= current_digit_next;
      dwell_countdown <= dwell_countdown_next;
      for (int k = 0; k < BANKS; k++) begin
        digit_bytes[k] <= digit_bytes_next[k];
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_byte  <= skid_byte;
        out_digit <= skid_digit;
      end
    end else if (res_valid) begin
      if (!out_valid || take) begin
        out_byte  <= res_byte;
        out_digit <= res_digit;
      end else begin
        skid_byte  <= res_byte;
        skid_digit <= res_digit;
      end
    end
  end

`ifndef SYNTHESIS
  // the skid only fills behind a held output
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  // scrolling never runs more than one step past the tail
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, scroll_position} <= ({1'b0, text_length} + POS_W'(scrdsp_pkg::SCROLL_TAIL + 1)))
    else $error("scroll position beyond text tail");

  // a digit latch only comes from a scroll tick
  assert property (@(posedge clk) disable iff (rst)
    s2_latch |-> (s2_valid && (s2_kind == scrdsp_pkg::KIND_SCROLL)))
    else $error("digit latch without a scroll tick");

  // a stalled pipeline does not move its read stage
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s2_valid) && $stable(s2_latch)))
    else $error("read stage moved while stalled");
`endif

endmodule

`default_nettype wire
